// ===== hdl/iplpm_pkg.sv =====
package iplpm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [7:0]  port;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic en;
    } t_cmp_ctl;

endpackage

// ===== hdl/iplpm_table.sv =====
module iplpm_table (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [iplpm_pkg::ADDR_W-1:0] i_wr_addr,
    input  iplpm_pkg::t_entry           i_wr_data,
    input  logic [iplpm_pkg::ADDR_W-1:0] i_rd_addr,
    output iplpm_pkg::t_entry           o_rd_data
);

    iplpm_pkg::t_entry r_mem [iplpm_pkg::TABLE_DEPTH];
    iplpm_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/iplpm_match.sv =====
module iplpm_match (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iplpm_pkg::t_cmp_ctl  i_ctl,
    input  logic [31:0]          i_dest,
    input  iplpm_pkg::t_entry    i_entry,
    output logic                 o_found,
    output logic [31:0]          o_hop,
    output logic [7:0]           o_port
);

    logic        r_found;
    logic [31:0] r_best_mask;
    logic [31:0] r_best_hop;
    logic [7:0]  r_best_port;
    logic        match;
    logic        take;

    // Strict greater-than keeps the earlier entry on equal masks.
    assign match = (i_entry.mask & i_dest) == i_entry.prefix;
    assign take  = i_ctl.en && match && (!r_found || (i_entry.mask > r_best_mask));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_mask <= i_entry.mask;
            r_best_hop  <= i_entry.hop;
            r_best_port <= i_entry.port;
        end
    end

    assign o_found = r_found;
    assign o_hop   = r_found ? r_best_hop : 32'd0;
    assign o_port  = r_found ? r_best_port : 8'd0;

endmodule

// ===== hdl/ipv4_longest_prefix_route_lookup.sv =====
// Append, clear, unused codes and a lookup on an empty table go straight from
// accept to the put state; a lookup over stored entries scans them all first.
// Items are taken one at a time; the table is read one entry per cycle, and the next
// item is taken once the result of the last is loaded into the output register.
// Reset (i_rst_n, synchronous, active low) empties the table at once; the
// stored words are not cleared and are never read before being rewritten.
module ipv4_longest_prefix_route_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_dest_addr,
    input  logic [31:0] i_route_prefix,
    input  logic [31:0] i_route_mask,
    input  logic [31:0] i_hop_addr,
    input  logic [7:0]  i_port_id,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [31:0] o_found_hop,
    output logic [7:0]  o_found_port,
    output logic        o_status
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_PUT  = 3'b100
    } t_state;

    localparam int CW = iplpm_pkg::CNT_W;
    localparam int AW = iplpm_pkg::ADDR_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;   // valid entries
    logic [CW-1:0]         r_idx, n_idx;       // next entry to read
    logic                  r_dv, n_dv;         // read data valid this cycle
    logic                  r_dv_last, n_dv_last;
    logic [31:0]           r_dest;
    logic                  r_status, n_status;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [31:0]           r_out_hop;
    logic [7:0]            r_out_port;
    logic                  r_out_status;

    logic                  accept;
    logic                  out_free;
    logic                  issue;
    logic                  full;
    logic                  wr_en;
    iplpm_pkg::t_entry     wr_data;
    iplpm_pkg::t_entry     rd_data;
    iplpm_pkg::t_cmp_ctl   cmp_ctl;
    logic                  m_found;
    logic [31:0]           m_hop;
    logic [7:0]            m_port;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign full       = (r_count == CW'(iplpm_pkg::TABLE_DEPTH));
    assign issue      = (r_state == ST_SCAN) && (r_idx != r_count);

    // Append writes straight into the slot after the last valid entry.
    assign wr_en   = accept && (i_req_type == iplpm_pkg::REQ_APPEND) && !full;
    assign wr_data = '{prefix: i_route_prefix, mask: i_route_mask,
                       hop: i_hop_addr, port: i_port_id};

    iplpm_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Reset the best-match tracker on every accepted item; feed it each
    // entry the cycle after its read was issued.
    assign cmp_ctl = '{clear: accept, en: r_dv};

    iplpm_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cmp_ctl),
        .i_dest  (r_dest),
        .i_entry (rd_data),
        .o_found (m_found),
        .o_hop   (m_hop),
        .o_port  (m_port)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_dv      = issue;
        n_dv_last = issue && ((r_idx + CW'(1)) == r_count);
        n_status  = r_status;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_status = 1'b0;
                    n_idx    = '0;
                    n_state  = ST_PUT;
                    case (i_req_type)
                        iplpm_pkg::REQ_APPEND: begin
                            if (full) begin
                                n_status = 1'b1;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        iplpm_pkg::REQ_CLEAR: begin
                            n_count = '0;
                        end
                        iplpm_pkg::REQ_LOOKUP: begin
                            // Empty table: report a miss right away.
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                // Last entry reaches the tracker this cycle.
                if (r_dv && r_dv_last) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_dv      <= 1'b0;
            r_dv_last <= 1'b0;
            r_status  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_dv      <= n_dv;
            r_dv_last <= n_dv_last;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dest <= i_dest_addr;
        end
    end

    // Output register: hold the result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_PUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_PUT) && out_free) begin
            r_out_hit    <= m_found;
            r_out_hop    <= m_hop;
            r_out_port   <= m_port;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_found_hop  = r_out_hop;
    assign o_found_port = r_out_port;
    assign o_status     = r_out_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(iplpm_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_dv_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == ST_SCAN))
        else $error("table data valid outside scan");

    a_put_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PUT) && out_free) |=> o_out_valid)
        else $error("result not presented after put");

    a_hit_no_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> !o_status)
        else $error("hit and refused append in one result");
`endif

endmodule
